// ===== rtl/bnkk_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bnkk_pkg
// Shared types and constants for the bounded nearest key keeper.
// ----------------------------------------------------------------------------
package bnkk_pkg;

  localparam int KEY_W       = 32;
  localparam int TAG_W       = 16;
  localparam int DROP_W      = 16;
  localparam int SLOT_W      = 4;
  localparam int KIND_W      = 3;
  localparam int LIMIT_W     = 5;
  localparam int IN_DATA_W   = 48;  // key, payload
  localparam int OUT_DATA_W  = 72;  // slot, key, payload, dropped total, pad
  localparam int OUT_PAD_W   = OUT_DATA_W - SLOT_W - KEY_W - TAG_W - DROP_W;

  localparam logic [LIMIT_W-1:0] LIMIT_RST = 5'd16;
  localparam logic [DROP_W-1:0]  DROP_MAX  = 16'hFFFF;

  typedef enum logic [KIND_W-1:0] {
    KIND_APPEND  = 3'd0,
    KIND_REPLACE = 3'd1,
    KIND_DISCARD = 3'd2,
    KIND_KEPT    = 3'd3,
    KIND_EMPTY   = 3'd4
  } kind_t;

  // controller -> datapath
  typedef struct packed {
    logic  load_in;     // latch the accepted request
    logic  drop_inc;    // count one dropped item
    logic  idx_clr;     // restart slot walk
    logic  rd_issue;    // read slot at walk index, advance index
    logic  cmp_en;      // fold read slot into worst-slot search
    logic  wr_append;   // write request at fill position
    logic  wr_replace;  // write request over worst slot
    logic  out_load;    // load output register
    logic  flush_clr;   // empty the table and the drop counter
    kind_t out_kind;
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_flush;
    logic fill_lt_cap;
    logic fill_zero;
    logic cap_zero;
    logic idx_at_fill;
    logic last_entry;
    logic nearer;
    logic out_free;
  } dp_sts_t;

endpackage

// ===== rtl/bnkk_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bnkk_ctrl
// Sequencer: dispatches insert / flush requests and steps the slot walk.
// ----------------------------------------------------------------------------
module bnkk_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  bnkk_pkg::dp_sts_t    sts,
  output bnkk_pkg::ctrl_cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_APPEND,
    S_DISCARD,
    S_EMPTY,
    S_SCAN,
    S_DECIDE,
    S_FREAD,
    S_FEMIT
  } state_t;

  state_t state_r, state_nxt;
  logic   in_tready_r;

  assign in_tready = in_tready_r;

  always_comb begin
    state_nxt    = state_r;
    cmd          = '0;
    cmd.out_kind = bnkk_pkg::KIND_DISCARD;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid && in_tready_r) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (sts.is_flush) begin
          if (sts.fill_zero) begin
            state_nxt = S_EMPTY;
          end else begin
            cmd.idx_clr = 1'b1;
            state_nxt   = S_FREAD;
          end
        end else if (sts.fill_lt_cap) begin
          state_nxt = S_APPEND;
        end else begin
          cmd.drop_inc = 1'b1;
          if (sts.cap_zero || sts.fill_zero) begin
            state_nxt = S_DISCARD;
          end else begin
            cmd.idx_clr = 1'b1;
            state_nxt   = S_SCAN;
          end
        end
      end
      S_APPEND: begin
        if (sts.out_free) begin
          cmd.wr_append = 1'b1;
          cmd.out_load  = 1'b1;
          cmd.out_kind  = bnkk_pkg::KIND_APPEND;
          state_nxt     = S_IDLE;
        end
      end
      S_DISCARD: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_kind = bnkk_pkg::KIND_DISCARD;
          state_nxt    = S_IDLE;
        end
      end
      S_EMPTY: begin
        if (sts.out_free) begin
          cmd.out_load  = 1'b1;
          cmd.out_kind  = bnkk_pkg::KIND_EMPTY;
          cmd.flush_clr = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_SCAN: begin
        // read one slot per cycle; the compare follows each read in the next cycle
        cmd.cmp_en   = 1'b1;
        cmd.rd_issue = !sts.idx_at_fill;
        if (sts.idx_at_fill) begin
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          if (sts.nearer) begin
            cmd.wr_replace = 1'b1;
            cmd.out_kind   = bnkk_pkg::KIND_REPLACE;
          end else begin
            cmd.out_kind   = bnkk_pkg::KIND_DISCARD;
          end
          state_nxt = S_IDLE;
        end
      end
      S_FREAD: begin
        cmd.rd_issue = 1'b1;
        state_nxt    = S_FEMIT;
      end
      S_FEMIT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_kind = bnkk_pkg::KIND_KEPT;
          if (sts.last_entry) begin
            cmd.flush_clr = 1'b1;
            state_nxt     = S_IDLE;
          end else begin
            state_nxt     = S_FREAD;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      in_tready_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      in_tready_r <= (state_nxt == S_IDLE);
    end
  end

`ifndef NO_ASSERTIONS
  a_load_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> sts.out_free)
    else $error("output register loaded while occupied");

  a_append_below_cap: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr_append |-> sts.fill_lt_cap)
    else $error("append into a full table");

  a_flush_empties: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.flush_clr |=> sts.fill_zero)
    else $error("table not empty after flush");
`endif

endmodule

// ===== rtl/bnkk_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bnkk_dp
// Datapath: entry memory, fill / drop counters, worst-slot search, output reg.
// ----------------------------------------------------------------------------
module bnkk_dp #(
  parameter int MAX_KEPT = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_wr_en,
  input  logic [bnkk_pkg::LIMIT_W-1:0]        cfg_wr_data,
  input  logic [0:0]                          in_tuser,
  input  logic [bnkk_pkg::IN_DATA_W-1:0]      in_tdata,
  input  bnkk_pkg::ctrl_cmd_t                 cmd,
  output bnkk_pkg::dp_sts_t                   sts,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [bnkk_pkg::OUT_DATA_W-1:0]     out_tdata,
  output logic [bnkk_pkg::KIND_W-1:0]         out_tuser,
  output logic                                out_tlast
);

  localparam int IDX_W = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
  localparam int CNT_W = $clog2(MAX_KEPT + 1);
  localparam int CAP_W = (CNT_W > bnkk_pkg::LIMIT_W) ? CNT_W : bnkk_pkg::LIMIT_W;
  localparam logic [CAP_W-1:0] CAP_MAX = CAP_W'(MAX_KEPT);

  // entry memory
  logic [bnkk_pkg::KEY_W-1:0] mem_key [MAX_KEPT];
  logic [bnkk_pkg::TAG_W-1:0] mem_tag [MAX_KEPT];

  logic [bnkk_pkg::LIMIT_W-1:0] limit_r;
  logic                         is_flush_r;
  logic [bnkk_pkg::KEY_W-1:0]   key_r;
  logic [bnkk_pkg::TAG_W-1:0]   tag_r;
  logic [CNT_W-1:0]             fill_r;
  logic [bnkk_pkg::DROP_W-1:0]  drop_r;
  logic [CNT_W-1:0]             idx_r;
  logic                         pend_r;
  logic [IDX_W-1:0]             rd_idx_r;
  logic [bnkk_pkg::KEY_W-1:0]   rkey_r;
  logic [bnkk_pkg::TAG_W-1:0]   rtag_r;
  logic [IDX_W-1:0]             worst_r;
  logic [bnkk_pkg::KEY_W-1:0]   wkey_r;
  logic                         wunk_r;

  logic                         out_valid_r;
  bnkk_pkg::kind_t              out_kind_r;
  logic [bnkk_pkg::SLOT_W-1:0]  out_slot_r;
  logic [bnkk_pkg::KEY_W-1:0]   out_key_r;
  logic [bnkk_pkg::TAG_W-1:0]   out_tag_r;
  logic [bnkk_pkg::DROP_W-1:0]  out_drop_r;
  logic                         out_last_r;

  logic [CAP_W-1:0]             limit_ext;
  logic [CAP_W-1:0]             cap;
  logic [CAP_W-1:0]             fill_ext;
  logic [CNT_W:0]               rd_next;
  logic                         rk_unk;
  logic                         worse;
  logic                         wr_en;
  logic [IDX_W-1:0]             wr_addr;
  logic [IDX_W-1:0]             slot_sel;
  logic [IDX_W+bnkk_pkg::SLOT_W-1:0] slot_ext;
  logic                         out_free;

  assign limit_ext = CAP_W'(limit_r);
  assign cap       = (limit_ext > CAP_MAX) ? CAP_MAX : limit_ext;
  assign fill_ext  = CAP_W'(fill_r);
  assign rd_next   = (CNT_W + 1)'(rd_idx_r) + 1'b1;
  assign out_free  = !out_valid_r || out_tready;

  // unknown key ranks farthest; ties keep the earlier slot
  assign rk_unk = (rkey_r == '0);
  assign worse  = (rd_idx_r == '0) || (rk_unk && !wunk_r) ||
                  ((rk_unk == wunk_r) && (rkey_r > wkey_r));

  assign wr_en   = cmd.wr_append || cmd.wr_replace;
  assign wr_addr = cmd.wr_append ? fill_r[IDX_W-1:0] : worst_r;

  always_comb begin
    sts             = '0;
    sts.is_flush    = is_flush_r;
    sts.fill_lt_cap = fill_ext < cap;
    sts.fill_zero   = (fill_r == '0);
    sts.cap_zero    = (cap == '0);
    sts.idx_at_fill = (idx_r == fill_r);
    sts.last_entry  = (rd_next == {1'b0, fill_r});
    sts.nearer      = (key_r != '0) && (wunk_r || (key_r < wkey_r));
    sts.out_free    = out_free;
  end

  always_comb begin
    case (cmd.out_kind)
      bnkk_pkg::KIND_APPEND:  slot_sel = fill_r[IDX_W-1:0];
      bnkk_pkg::KIND_REPLACE: slot_sel = worst_r;
      bnkk_pkg::KIND_KEPT:    slot_sel = rd_idx_r;
      default:                slot_sel = '0;
    endcase
  end
  assign slot_ext = {{bnkk_pkg::SLOT_W{1'b0}}, slot_sel};

  // memory write and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_key[wr_addr] <= key_r;
      mem_tag[wr_addr] <= tag_r;
    end
    if (cmd.rd_issue) begin
      rkey_r   <= mem_key[idx_r[IDX_W-1:0]];
      rtag_r   <= mem_tag[idx_r[IDX_W-1:0]];
      rd_idx_r <= idx_r[IDX_W-1:0];
    end
  end

  // request hold, worst-slot tracking and output register load
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      is_flush_r <= in_tuser[0];
      key_r      <= in_tdata[bnkk_pkg::KEY_W-1:0];
      tag_r      <= in_tdata[bnkk_pkg::KEY_W +: bnkk_pkg::TAG_W];
    end
    if (cmd.cmp_en && pend_r && worse) begin
      worst_r <= rd_idx_r;
      wkey_r  <= rkey_r;
      wunk_r  <= rk_unk;
    end
    if (cmd.out_load) begin
      out_kind_r <= cmd.out_kind;
      out_slot_r <= slot_ext[bnkk_pkg::SLOT_W-1:0];
      out_key_r  <= (cmd.out_kind == bnkk_pkg::KIND_KEPT) ? rkey_r : '0;
      out_tag_r  <= (cmd.out_kind == bnkk_pkg::KIND_KEPT) ? rtag_r : '0;
      out_drop_r <= drop_r;
      out_last_r <= (cmd.out_kind == bnkk_pkg::KIND_KEPT) ? sts.last_entry : 1'b1;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r     <= bnkk_pkg::LIMIT_RST;
      fill_r      <= '0;
      drop_r      <= '0;
      idx_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        limit_r <= cfg_wr_data;
      end
      if (cmd.flush_clr) begin
        fill_r <= '0;
      end else if (cmd.wr_append) begin
        fill_r <= fill_r + 1'b1;
      end
      if (cmd.flush_clr) begin
        drop_r <= '0;
      end else if (cmd.drop_inc && (drop_r != bnkk_pkg::DROP_MAX)) begin
        drop_r <= drop_r + 1'b1;
      end
      if (cmd.idx_clr) begin
        idx_r <= '0;
      end else if (cmd.rd_issue) begin
        idx_r <= idx_r + 1'b1;
      end
      pend_r <= cmd.rd_issue;
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {{bnkk_pkg::OUT_PAD_W{1'b0}}, out_drop_r, out_tag_r, out_key_r,
                       out_slot_r};

`ifndef NO_ASSERTIONS
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CNT_W'(MAX_KEPT))
    else $error("fill count beyond table depth");

  a_drop_saturates: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(drop_r) == bnkk_pkg::DROP_MAX && !$past(cmd.flush_clr)) |->
      drop_r == bnkk_pkg::DROP_MAX)
    else $error("drop counter wrapped");
`endif

endmodule

// ===== rtl/bounded_nearest_key_keeper.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_nearest_key_keeper
// Keeps up to min(keep_limit, MAX_KEPT) tagged items with the nearest time keys.
// ----------------------------------------------------------------------------
// One request is handled at a time. An insert into a table with room passes
// through the dispatch and append states before the next acceptance. An insert
// into a full table walks every held slot through the single read port of the
// entry memory, one slot per cycle, to find the worst key. A flush alternates
// a read state and an emit state for each held entry, and an empty table gives
// one empty marker. A result sits in an output register; the next request is
// taken while it waits, and the walk stalls only when a new result is due and
// the register has not been taken. Key zero means unknown and ranks farthest.
// Insert results carry zero key and tag; dropped_total is the count after the
// insert, or the count before the clear on a flush.
// ----------------------------------------------------------------------------
module bounded_nearest_key_keeper #(
  parameter int MAX_KEPT = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // config: keep_limit
  input  logic                             cfg_wr_en,
  input  logic [bnkk_pkg::LIMIT_W-1:0]     cfg_wr_data,
  // request stream
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [bnkk_pkg::IN_DATA_W-1:0]   in_tdata,   // key[31:0], payload[47:32]
  input  logic [0:0]                       in_tuser,   // cmd[0]: 0 insert, 1 flush
  // result stream
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [bnkk_pkg::OUT_DATA_W-1:0]  out_tdata,  // slot[3:0], out_key[35:4],
                                                        // out_payload[51:36],
                                                        // dropped_total[67:52], 0
  output logic [bnkk_pkg::KIND_W-1:0]      out_tuser,  // kind[2:0]
  output logic                             out_tlast
);

  bnkk_pkg::ctrl_cmd_t cmd;
  bnkk_pkg::dp_sts_t   sts;

  // sequencer
  bnkk_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // table, counters, search and output register
  bnkk_dp #(
    .MAX_KEPT (MAX_KEPT)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tuser    (in_tuser),
    .in_tdata    (in_tdata),
    .cmd         (cmd),
    .sts         (sts),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast)
  );

endmodule

// ===== sim/bnkk_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bnkk_checker
// Scoreboard for the bounded nearest key keeper: it tracks the keep limit,
// models the slot table for every accepted request and compares each
// accepted result with the oldest one still due.
// ----------------------------------------------------------------------------
module bnkk_checker #(
  parameter int MAX_KEPT = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_wr_en,
  input  logic [bnkk_pkg::LIMIT_W-1:0]    cfg_wr_data,
  input  logic                            in_tvalid,
  input  logic                            in_tready,
  input  logic [bnkk_pkg::IN_DATA_W-1:0]  in_tdata,   // key[31:0], payload[47:32]
  input  logic [0:0]                      in_tuser,   // cmd[0]
  input  logic                            out_tvalid,
  input  logic                            out_tready,
  input  logic [bnkk_pkg::OUT_DATA_W-1:0] out_tdata,  // slot, out_key, out_payload,
                                                      // dropped_total, zero pad
  input  logic [bnkk_pkg::KIND_W-1:0]     out_tuser,  // kind[2:0]
  input  logic                            out_tlast,
  output int                              mismatch_count,
  output int                              results_due
);

  typedef struct packed {
    bnkk_pkg::kind_t             kind;
    logic [bnkk_pkg::SLOT_W-1:0] slot;
    logic [bnkk_pkg::KEY_W-1:0]  key;
    logic [bnkk_pkg::TAG_W-1:0]  tag;
    logic [bnkk_pkg::DROP_W-1:0] drops;
    logic                        last;
  } outcome_t;

  logic [bnkk_pkg::KEY_W-1:0]   held_key [MAX_KEPT];
  logic [bnkk_pkg::TAG_W-1:0]   held_tag [MAX_KEPT];
  int                           fill_level;
  logic [bnkk_pkg::DROP_W-1:0]  lost_items;
  logic [bnkk_pkg::LIMIT_W-1:0] keep_limit;
  outcome_t                     due_q[$];
  int                           errors = 0;

  initial begin
    mismatch_count = 0;
    results_due    = 0;
  end

  function automatic outcome_t make_outcome(bnkk_pkg::kind_t kind, int slot,
                                            logic [bnkk_pkg::KEY_W-1:0] key,
                                            logic [bnkk_pkg::TAG_W-1:0] tag,
                                            logic last);
    outcome_t o;
    o.kind  = kind;
    o.slot  = slot[bnkk_pkg::SLOT_W-1:0];
    o.key   = key;
    o.tag   = tag;
    o.drops = lost_items;
    o.last  = last;
    return o;
  endfunction

  task automatic queue_result(input outcome_t o);
    due_q.insert(due_q.size(), o);
  endtask

  // Table update for one request; queues the results it produces.
  task automatic predict_request(input logic flush, input logic [bnkk_pkg::KEY_W-1:0] key,
                                 input logic [bnkk_pkg::TAG_W-1:0] tag);
    int   cap;
    int   worst;
    int   i;
    logic unknown;
    logic worst_unk;
    cap = (keep_limit > MAX_KEPT) ? MAX_KEPT : int'(keep_limit);
    if (flush) begin
      if (fill_level == 0)
        queue_result(make_outcome(bnkk_pkg::KIND_EMPTY, 0, '0, '0, 1'b1));
      for (i = 0; i < fill_level; i++)
        queue_result(make_outcome(bnkk_pkg::KIND_KEPT, i, held_key[i], held_tag[i],
                                  i == fill_level - 1));
      fill_level = 0;
      lost_items = '0;
    end else if (fill_level < cap) begin
      held_key[fill_level] = key;
      held_tag[fill_level] = tag;
      queue_result(make_outcome(bnkk_pkg::KIND_APPEND, fill_level, '0, '0, 1'b1));
      fill_level++;
    end else begin
      if (lost_items != bnkk_pkg::DROP_MAX)
        lost_items++;
      if (cap == 0 || fill_level == 0) begin
        queue_result(make_outcome(bnkk_pkg::KIND_DISCARD, 0, '0, '0, 1'b1));
      end else begin
        // unknown keys rank farthest; ties keep the first slot
        worst = 0;
        for (i = 1; i < fill_level; i++) begin
          unknown   = (held_key[i] == '0);
          worst_unk = (held_key[worst] == '0);
          if ((unknown && !worst_unk) ||
              (unknown == worst_unk && held_key[i] > held_key[worst]))
            worst = i;
        end
        worst_unk = (held_key[worst] == '0);
        if (key != '0 && (worst_unk || key < held_key[worst])) begin
          held_key[worst] = key;
          held_tag[worst] = tag;
          queue_result(make_outcome(bnkk_pkg::KIND_REPLACE, worst, '0, '0, 1'b1));
        end else begin
          queue_result(make_outcome(bnkk_pkg::KIND_DISCARD, 0, '0, '0, 1'b1));
        end
      end
    end
  endtask

  always @(posedge clk) begin
    outcome_t seen;
    outcome_t want;
    if (!rst_n) begin
      due_q.delete();
      fill_level = 0;
      lost_items = '0;
      keep_limit = bnkk_pkg::LIMIT_RST;
    end else begin
      if (cfg_wr_en)
        keep_limit = cfg_wr_data;
      if (out_tvalid && out_tready) begin
        seen.kind  = bnkk_pkg::kind_t'(out_tuser);
        seen.slot  = out_tdata[bnkk_pkg::SLOT_W-1:0];
        seen.key   = out_tdata[bnkk_pkg::SLOT_W +: bnkk_pkg::KEY_W];
        seen.tag   = out_tdata[bnkk_pkg::SLOT_W+bnkk_pkg::KEY_W +: bnkk_pkg::TAG_W];
        seen.drops = out_tdata[bnkk_pkg::SLOT_W+bnkk_pkg::KEY_W+bnkk_pkg::TAG_W +:
                               bnkk_pkg::DROP_W];
        seen.last  = out_tlast;
        if (due_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, expected none, got kind %0d slot %0d key %h",
                   $time, seen.kind, seen.slot, seen.key,
                   " tag %h dropped %0d last %0b", seen.tag, seen.drops, seen.last);
        end else begin
          want = due_q.pop_front();
          if (seen !== want) begin
            errors++;
            $display("%0t: result mismatch, expected kind %0d slot %0d key %h tag %h",
                     $time, want.kind, want.slot, want.key, want.tag,
                     " dropped %0d last %0b, got kind %0d slot %0d key %h tag %h",
                     want.drops, want.last, seen.kind, seen.slot, seen.key, seen.tag,
                     " dropped %0d last %0b", seen.drops, seen.last);
          end
        end
      end
      if (in_tvalid && in_tready)
        predict_request(in_tuser[0], in_tdata[bnkk_pkg::KEY_W-1:0],
                        in_tdata[bnkk_pkg::KEY_W +: bnkk_pkg::TAG_W]);
    end
    results_due    <= due_q.size();
    mismatch_count <= errors;
  end

endmodule

// ===== sim/bounded_nearest_key_keeper_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_nearest_key_keeper_test
// Drives requests and keep limits into the keeper, applies random
// backpressure and reports the verdict from the checker's mismatch count.
// ----------------------------------------------------------------------------
module bounded_nearest_key_keeper_test;

  localparam int   MAX_KEPT     = 16;
  localparam logic CMD_INSERT   = 1'b0;
  localparam logic CMD_FLUSH    = 1'b1;

  logic                            clk;
  logic                            rst_n;
  logic                            cfg_wr_en;
  logic [bnkk_pkg::LIMIT_W-1:0]    cfg_wr_data;
  logic                            in_tvalid;
  logic                            in_tready;
  logic [bnkk_pkg::IN_DATA_W-1:0]  in_tdata;   // key[31:0], payload[47:32]
  logic [0:0]                      in_tuser;   // cmd[0]
  logic                            out_tvalid;
  logic                            out_tready;
  logic [bnkk_pkg::OUT_DATA_W-1:0] out_tdata;  // slot, out_key, out_payload,
                                               // dropped_total, pad
  logic [bnkk_pkg::KIND_W-1:0]     out_tuser;  // kind[2:0]
  logic                            out_tlast;

  int mismatch_count;
  int results_due;
  bit calm = 1'b0;      // set for the closing part: no gaps, no stalls
  int stall_left = 0;

  // keep limits walked by the random phases; phases do not flush before a
  // limit change, so a lowered limit regularly lands below the fill level
  logic [bnkk_pkg::LIMIT_W-1:0] phase_limits [10] =
    '{5'd16, 5'd1, 5'd31, 5'd5, 5'd17, 5'd0, 5'd2, 5'd16, 5'd9, 5'd3};

  bounded_nearest_key_keeper #(.MAX_KEPT(MAX_KEPT)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  bnkk_checker #(.MAX_KEPT(MAX_KEPT)) scoreboard (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .in_tuser      (in_tuser),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .out_tuser     (out_tuser),
    .out_tlast     (out_tlast),
    .mismatch_count(mismatch_count),
    .results_due   (results_due)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Result side backpressure: random stall bursts, none once calm.
  initial out_tready = 1'b0;
  always @(posedge clk) begin
    if (calm) begin
      out_tready <= 1'b1;
    end else if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 5) == 0) begin
      out_tready <= 1'b0;
      stall_left <= $urandom_range(0, 4);
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Keys lean toward zero, all ones and a small range so that ties and
  // unknown keys show up often in the worst-slot search.
  function automatic logic [bnkk_pkg::KEY_W-1:0] pick_key();
    case ($urandom_range(0, 9))
      0:          return '0;
      1:          return '1;
      2, 3, 4, 5: return bnkk_pkg::KEY_W'($urandom_range(1, 24));
      default:    return $urandom();
    endcase
  endfunction

  // One request; returns at the edge where it is accepted. valid stays high
  // unless a gap is chosen, so back-to-back requests never toggle it.
  task automatic send_request(input logic cmd, input logic [bnkk_pkg::KEY_W-1:0] key,
                              input logic [bnkk_pkg::TAG_W-1:0] tag);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {tag, key};
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic insert(input logic [bnkk_pkg::KEY_W-1:0] key,
                        input logic [bnkk_pkg::TAG_W-1:0] tag);
    send_request(CMD_INSERT, key, tag);
  endtask

  // flush ignores key and payload, so they carry noise
  task automatic flush();
    send_request(CMD_FLUSH, $urandom(), bnkk_pkg::TAG_W'($urandom()));
  endtask

  // Drop valid and wait until the checker holds no pending result. The
  // count is registered, so look only from the next edge on.
  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (results_due != 0) @(posedge clk);
  endtask

  // Every request yields at least one result, so once nothing is due the
  // keeper is idle and the limit may change.
  task automatic write_limit(input logic [bnkk_pkg::LIMIT_W-1:0] value);
    settle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  initial begin
    rst_n       <= 1'b0;
    cfg_wr_en   <= 1'b0;
    cfg_wr_data <= '0;
    in_tvalid   <= 1'b0;
    in_tdata    <= '0;
    in_tuser    <= CMD_INSERT;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // --- directed -----------------------------------------------------------
    // reset limit: empty flush marker, then extreme keys and payloads
    flush();
    insert('1, '1);
    insert('0, '0);
    // limit 3: three appends (one an unknown key), unknown key replaced first,
    // equal key is not nearer, then flush of three
    write_limit(5'd3);
    insert(32'd5, 16'h1234);
    insert(32'd7, 16'h8000);
    insert('0, 16'h00ff);
    insert(32'd9, 16'h7fff);
    insert(32'd9, 16'h5555);
    flush();
    // limit lowered below fill: scan still covers all held entries
    insert(32'd40, 16'haaaa);
    insert(32'd30, 16'h0001);
    insert(32'd50, 16'hfffe);
    write_limit(5'd1);
    insert(32'd2, 16'h4321);
    insert(32'hffff_fffe, 16'h0f0f);
    flush();
    // zero limit: every insert is discarded at slot zero
    write_limit(5'd0);
    insert(32'd1, 16'hffff);
    insert('0, '0);
    flush();

    // --- random phases ------------------------------------------------------
    foreach (phase_limits[p]) begin
      write_limit(phase_limits[p]);
      repeat (28) begin
        if ($urandom_range(0, 15) == 0)
          flush();
        else
          insert(pick_key(), bnkk_pkg::TAG_W'($urandom()));
      end
    end

    // --- closing part: no gaps, no stalls -----------------------------------
    // Full table at limit 16, the table depth, then inserts that scan every slot
    // back to back, and a flush of all sixteen entries.
    calm = 1'b1;
    flush();
    write_limit(5'd16);
    repeat (20) insert(pick_key(), bnkk_pkg::TAG_W'($urandom()));
    flush();

    // drain, then give a stray extra result time to show up
    settle();
    repeat (MAX_KEPT + 8) @(posedge clk);
    if (mismatch_count == 0)
      $display("bounded_nearest_key_keeper verification clean");
    else
      $display("bounded_nearest_key_keeper verification failed");
    $finish;
  end

  // watchdog, well beyond the slowest legal run
  initial begin
    #20_000_000;
    $display("bounded_nearest_key_keeper verification failed");
    $finish;
  end

endmodule
